@@ rtl/fcpu_pkg.sv @@
// Shared types, constants and the CORDIC angle table for the fly camera pose block.
package fcpu_pkg;

   localparam int SpeedWidth = 24;
   localparam int SensWidth  = 16;
   localparam int CsrWidth   = 24;
   localparam int QueueDepth = 2;

   localparam logic [1:0] ACT_KEY    = 2'd0;
   localparam logic [1:0] ACT_MOUSE  = 2'd1;
   localparam logic [1:0] ACT_SET    = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam logic [0:0] CSR_MOVE_SPEED = 1'd0;
   localparam logic [0:0] CSR_LOOK_SENS  = 1'd1;

   localparam logic [7:0] KEY_W = 8'h77;
   localparam logic [7:0] KEY_S = 8'h73;
   localparam logic [7:0] KEY_A = 8'h61;
   localparam logic [7:0] KEY_D = 8'h64;
   localparam logic [7:0] KEY_Q = 8'h71;
   localparam logic [7:0] KEY_E = 8'h65;

   // classified operations handed from front to back
   localparam logic [2:0] OP_NONE   = 3'd0;
   localparam logic [2:0] OP_FWD    = 3'd1;
   localparam logic [2:0] OP_UP     = 3'd2;
   localparam logic [2:0] OP_STRAFE = 3'd3;
   localparam logic [2:0] OP_MOUSE  = 3'd4;
   localparam logic [2:0] OP_SET    = 3'd5;

   localparam logic [15:0] ANG_FULL    = 16'd46080;
   localparam logic [15:0] ANG_QUARTER = 16'd11520;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

   typedef struct packed {
      logic [1:0]         action;
      logic [7:0]         key_code;
      logic signed [15:0] mouse_x;
      logic signed [15:0] mouse_y;
      logic signed [31:0] new_x;
      logic signed [31:0] new_y;
      logic signed [31:0] new_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] front_x;
      logic signed [15:0] front_y;
      logic signed [15:0] front_z;
      logic               strafe_undefined;
   } rsp_type;

   // one classified command in the queue
   typedef struct packed {
      logic [2:0]         op;
      logic               neg;
      logic signed [15:0] mouse_x;
      logic signed [15:0] mouse_y;
      logic signed [31:0] new_x;
      logic signed [31:0] new_y;
      logic signed [31:0] new_z;
   } cmd_type;

   function automatic logic signed [23:0] atan_lut(input logic [3:0] i);
      logic signed [23:0] r;
      case (i)
         4'd0:  r = 24'sd2949120;
         4'd1:  r = 24'sd1740967;
         4'd2:  r = 24'sd919879;
         4'd3:  r = 24'sd466945;
         4'd4:  r = 24'sd234379;
         4'd5:  r = 24'sd117304;
         4'd6:  r = 24'sd58666;
         4'd7:  r = 24'sd29335;
         4'd8:  r = 24'sd14668;
         4'd9:  r = 24'sd7334;
         4'd10: r = 24'sd3667;
         4'd11: r = 24'sd1833;
         4'd12: r = 24'sd917;
         4'd13: r = 24'sd458;
         4'd14: r = 24'sd229;
         default: r = 24'sd115;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

@@ rtl/fcpu_chan_if.sv @@
// Valid/ready channel interface carrying one payload.
interface fcpu_chan_if #(parameter type PayloadType = logic);
   logic       valid;
   logic       ready;
   PayloadType payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/fly_camera_pose_update_top.sv @@
// Top level of the fly camera pose keeper.
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | action, key_code, mouse, new position
//  rsp     | out       | rsp_valid / rsp_ready  | position, front, strafe_undefined
//  csr     | in        | csr_write_enable       | csr_index, csr_write_data
// Set, up/down and ignored keys need no multiply; forward/back uses three products.
// Strafe runs an integer root, then two 40-step dividers.
// Mouse look wraps the angles, then runs two 16-step CORDIC passes.
// Reset (synchronous) restores the start pose; the front queue holds two
// transactions; a held response stalls the back end, then the front when full.
module fly_camera_pose_update_top #(
   parameter int QueueDepth = fcpu_pkg::QueueDepth
) (
   input  logic clock,
   input  logic reset,
   fcpu_chan_if.sink   req,
   fcpu_chan_if.source rsp,
   input  logic                          csr_write_enable,
   input  logic [0:0]                    csr_index,
   input  logic [fcpu_pkg::CsrWidth-1:0] csr_write_data
);
   logic [fcpu_pkg::SpeedWidth-1:0] speed_ff;
   logic [fcpu_pkg::SensWidth-1:0]  sens_ff;
   logic                            cmd_valid, cmd_ready;
   fcpu_pkg::cmd_type               cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= fcpu_pkg::SpeedWidth'(20480);
         sens_ff <= fcpu_pkg::SensWidth'(6554);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            fcpu_pkg::CSR_MOVE_SPEED: speed_ff <= csr_write_data[fcpu_pkg::SpeedWidth-1:0];
            fcpu_pkg::CSR_LOOK_SENS:  sens_ff <= csr_write_data[fcpu_pkg::SensWidth-1:0];
            default: ;
         endcase
      end
   end

   fcpu_front #(.QueueDepth(QueueDepth)) u_front (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready), .req_payload(req.payload),
      .cmd_valid, .cmd_ready, .cmd
   );

   fcpu_back u_back (
      .clock, .reset, .move_speed(speed_ff), .look_sens(sens_ff),
      .cmd_valid, .cmd_ready, .cmd,
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
   );
endmodule

@@ rtl/fcpu_front.sv @@
// Front end: accepts requests, classifies them and queues commands.
module fcpu_front #(
   parameter int QueueDepth = fcpu_pkg::QueueDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fcpu_pkg::req_type req_payload,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output fcpu_pkg::cmd_type cmd
);
   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);

   fcpu_pkg::cmd_type   q_ff [QueueDepth];
   logic [PtrW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   fcpu_pkg::cmd_type   cls;
   logic                push, pop;

   always_comb begin
      cls = '0;
      cls.mouse_x = req_payload.mouse_x;
      cls.mouse_y = req_payload.mouse_y;
      cls.new_x = req_payload.new_x;
      cls.new_y = req_payload.new_y;
      cls.new_z = req_payload.new_z;
      cls.op = fcpu_pkg::OP_NONE;
      unique case (req_payload.action)
         fcpu_pkg::ACT_KEY: begin
            case (req_payload.key_code)
               fcpu_pkg::KEY_W: cls.op = fcpu_pkg::OP_FWD;
               fcpu_pkg::KEY_S: begin cls.op = fcpu_pkg::OP_FWD; cls.neg = 1'b1; end
               fcpu_pkg::KEY_Q: cls.op = fcpu_pkg::OP_UP;
               fcpu_pkg::KEY_E: begin cls.op = fcpu_pkg::OP_UP; cls.neg = 1'b1; end
               fcpu_pkg::KEY_D: cls.op = fcpu_pkg::OP_STRAFE;
               fcpu_pkg::KEY_A: begin cls.op = fcpu_pkg::OP_STRAFE; cls.neg = 1'b1; end
               default: cls.op = fcpu_pkg::OP_NONE;
            endcase
         end
         fcpu_pkg::ACT_MOUSE: cls.op = fcpu_pkg::OP_MOUSE;
         fcpu_pkg::ACT_SET:   cls.op = fcpu_pkg::OP_SET;
         default:             cls.op = fcpu_pkg::OP_NONE;
      endcase
   end

   assign req_ready = (cnt_ff != CntW'(QueueDepth));
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rd_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) wr_in = (wr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ff + 1'b1;
      if (pop)  rd_in = (rd_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ff + 1'b1;
      cnt_in = cnt_ff + CntW'(push) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= cls;
   end
endmodule

@@ rtl/fcpu_back.sv @@
// Back end: sequencer holding the pose, with shared multiplier, CORDIC,
// square root and divider steps.
module fcpu_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [fcpu_pkg::SpeedWidth-1:0] move_speed,
   input  logic [fcpu_pkg::SensWidth-1:0]  look_sens,
   input  logic                            cmd_valid,
   output logic                            cmd_ready,
   input  fcpu_pkg::cmd_type               cmd,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output fcpu_pkg::rsp_type               rsp_payload
);
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_FWD   = 4'd1;
   localparam logic [3:0] ST_SQRT  = 4'd2;
   localparam logic [3:0] ST_DIVX  = 4'd3;
   localparam logic [3:0] ST_DIVZ  = 4'd4;
   localparam logic [3:0] ST_TURN  = 4'd5;
   localparam logic [3:0] ST_WRAP  = 4'd6;
   localparam logic [3:0] ST_CORD  = 4'd7;
   localparam logic [3:0] ST_QUAD  = 4'd8;
   localparam logic [3:0] ST_VIEW  = 4'd9;
   localparam logic [3:0] ST_OUT   = 4'd10;
   localparam int DivW = fcpu_pkg::SpeedWidth + 16;

   logic [3:0] st_ff, st_in;
   logic [5:0] cnt_ff, cnt_in;
   fcpu_pkg::cmd_type cmd_ff, cmd_in;

   logic signed [31:0] px_ff, px_in, py_ff, py_in, pz_ff, pz_in;
   logic signed [15:0] vx_ff, vx_in, vy_ff, vy_in, vz_ff, vz_in;
   logic [15:0] yaw_ff, yaw_in, pit_ff, pit_in;
   logic signed [15:0] lpx_ff, lpx_in, lpy_ff, lpy_in;
   logic first_ff, first_in;
   logic flag_ff, flag_in;
   logic rv_ff, rv_in;

   // scratch
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [25:0] cz_ff, cz_in;
   logic [1:0] quad_ff, quad_in;
   logic signed [15:0] cyaw_ff, cyaw_in, syaw_ff, syaw_in;
   logic signed [33:0] dang_ff, dang_in;
   logic [31:0] rem_ff, rem_in;
   logic [15:0] root_ff, root_in;
   logic [DivW-1:0] dq_ff, dq_in;
   logic [DivW:0] dr_ff, dr_in;

   // shared multiplier, registered product
   logic signed [24:0] ma, mb;
   logic signed [49:0] prod_ff;

   function automatic logic signed [15:0] rnd_clamp(input logic signed [33:0] v);
      logic signed [33:0] t;
      t = (v + 34'sd32768) >>> 16;
      if (t > 34'sd16384) return fcpu_pkg::ONE_Q14;
      if (t < -34'sd16384) return -fcpu_pkg::ONE_Q14;
      return t[15:0];
   endfunction

   logic signed [15:0] cr, sr, qc, qs;
   logic signed [23:0] atan_v;
   logic [33:0] spx, spy;
   logic signed [33:0] rounded;
   logic [31:0] tst;
   logic [DivW:0] dtr;
   logic [DivW-1:0] num_abs;
   logic signed [33:0] qsgn;
   logic signed [49:0] pt;

   always_comb begin
      cr = rnd_clamp(cx_ff);
      sr = rnd_clamp(cy_ff);
      case (quad_ff)
         2'd0: begin qc = cr;  qs = sr;  end
         2'd1: begin qc = -sr; qs = cr;  end
         2'd2: begin qc = -cr; qs = -sr; end
         default: begin qc = sr; qs = -cr; end
      endcase
   end

   always_ff @(posedge clock) prod_ff <= ma * mb;

   always_comb begin
      st_in = st_ff; cnt_in = cnt_ff; cmd_in = cmd_ff;
      px_in = px_ff; py_in = py_ff; pz_in = pz_ff;
      vx_in = vx_ff; vy_in = vy_ff; vz_in = vz_ff;
      yaw_in = yaw_ff; pit_in = pit_ff; lpx_in = lpx_ff; lpy_in = lpy_ff;
      first_in = first_ff; flag_in = flag_ff; rv_in = rv_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff; quad_in = quad_ff;
      cyaw_in = cyaw_ff; syaw_in = syaw_ff; dang_in = dang_ff;
      rem_in = rem_ff; root_in = root_ff; dq_in = dq_ff; dr_in = dr_ff;
      ma = '0; mb = '0;
      atan_v = fcpu_pkg::atan_lut(cnt_ff[3:0]);
      spx = '0; spy = '0; rounded = '0; tst = '0; dtr = '0; num_abs = '0; qsgn = '0;
      pt = '0;
      cmd_ready = (st_ff == ST_IDLE) && !rv_ff;
      if (rv_ff && rsp_ready) rv_in = 1'b0;

      unique case (st_ff)
         ST_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               cmd_in = cmd; cnt_in = '0; flag_in = 1'b0;
               case (cmd.op)
                  fcpu_pkg::OP_FWD: st_in = ST_FWD;
                  fcpu_pkg::OP_UP: begin
                     spx = 34'(move_speed);
                     py_in = fcpu_pkg::sat32(cmd.neg ? {py_ff[31], py_ff[31], py_ff} - $signed(spx)
                                                     : {py_ff[31], py_ff[31], py_ff} + $signed(spx));
                     st_in = ST_OUT;
                  end
                  fcpu_pkg::OP_STRAFE: begin
                     if (vx_ff == 16'sd0 && vz_ff == 16'sd0) begin
                        flag_in = 1'b1; st_in = ST_OUT;
                     end else begin
                        rem_in = '0; root_in = '0; st_in = ST_SQRT;
                     end
                  end
                  fcpu_pkg::OP_MOUSE: begin
                     if (first_ff) begin
                        lpx_in = cmd.mouse_x; lpy_in = cmd.mouse_y; first_in = 1'b0;
                     end
                     st_in = ST_TURN;
                  end
                  fcpu_pkg::OP_SET: begin
                     px_in = cmd.new_x; py_in = cmd.new_y; pz_in = cmd.new_z;
                     st_in = ST_OUT;
                  end
                  default: st_in = ST_OUT;
               endcase
            end
         end
         ST_FWD: begin
            // cnt 0..2 issue, 1..3 accumulate
            ma = $signed(25'(move_speed));
            case (cnt_ff[1:0])
               2'd0: mb = 25'(vx_ff);
               2'd1: mb = 25'(vy_ff);
               default: mb = 25'(vz_ff);
            endcase
            if (cnt_ff != '0) begin
               pt = (prod_ff + 50'sd8192) >>> 14;
               rounded = pt[33:0];
               if (cmd_ff.neg) rounded = -rounded;
               case (cnt_ff[1:0])
                  2'd1: px_in = fcpu_pkg::sat32({px_ff[31], px_ff[31], px_ff} + rounded);
                  2'd2: py_in = fcpu_pkg::sat32({py_ff[31], py_ff[31], py_ff} + rounded);
                  default: pz_in = fcpu_pkg::sat32({pz_ff[31], pz_ff[31], pz_ff} + rounded);
               endcase
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd3) st_in = ST_OUT;
         end
         ST_SQRT: begin
            // cnt 0: vx^2, 1: vz^2, 2: summed, 3..18 root bits
            ma = 25'(vx_ff); mb = 25'(vx_ff);
            if (cnt_ff == 6'd1) begin ma = 25'(vz_ff); mb = 25'(vz_ff); end
            if (cnt_ff == 6'd1) rem_in = prod_ff[31:0];
            else if (cnt_ff == 6'd2) rem_in = rem_ff + prod_ff[31:0];
            else if (cnt_ff > 6'd2) begin
               // bitwise root: test bit 15-(cnt-3)
               tst = 32'(root_ff | (16'd1 << (5'd18 - 5'(cnt_ff))));
               if (32'(tst) * 32'(tst) <= rem_ff) root_in = tst[15:0];
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd18) begin cnt_in = '0; st_in = ST_DIVX; end
         end
         ST_DIVX, ST_DIVZ: begin
            // cnt 0: product; 1: load; 2..DivW+1: restoring division steps
            ma = $signed(25'(move_speed));
            mb = (st_ff == ST_DIVX) ? -25'(vz_ff) : 25'(vx_ff);
            if (cnt_ff == 6'd1) begin
               num_abs = prod_ff[49] ? DivW'(-prod_ff) : DivW'(prod_ff);
               dq_in = num_abs + DivW'(root_ff >> 1);
               dr_in = '0;
               cz_in = {25'd0, prod_ff[49]};
            end else if (cnt_ff > 6'd1) begin
               dtr = {dr_ff[DivW-1:0], dq_ff[DivW-1]};
               dq_in = {dq_ff[DivW-2:0], 1'b0};
               if (dtr >= (DivW+1)'(root_ff)) begin
                  dr_in = dtr - (DivW+1)'(root_ff); dq_in[0] = 1'b1;
               end else dr_in = dtr;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'(DivW + 1)) begin
               qsgn = 34'(dq_in);
               if (cz_ff[0] ^ cmd_ff.neg) qsgn = -qsgn;
               cnt_in = '0;
               if (st_ff == ST_DIVX) begin
                  px_in = fcpu_pkg::sat32({px_ff[31], px_ff[31], px_ff} + qsgn);
                  st_in = ST_DIVZ;
               end else begin
                  pz_in = fcpu_pkg::sat32({pz_ff[31], pz_ff[31], pz_ff} + qsgn);
                  st_in = ST_OUT;
               end
            end
         end
         ST_TURN: begin
            // cnt 0: yaw product, 1: pitch product / yaw delta, 2: pitch delta
            ma = 25'(17'(cmd_ff.mouse_x) - 17'(lpx_ff));
            if (cnt_ff == 6'd1) ma = 25'(17'(lpy_ff) - 17'(cmd_ff.mouse_y));
            mb = $signed({9'd0, look_sens});
            if (cnt_ff != '0) begin
               pt = prod_ff[49] ? -((-prod_ff + 50'sd256) >>> 9)
                                : ((prod_ff + 50'sd256) >>> 9);
               dang_in = pt[33:0] + ((cnt_ff == 6'd1) ? 34'(yaw_ff) : 34'(pit_ff));
               cnt_in = '0;
               st_in = ST_WRAP;
               // reuse quad_ff[0] to mark pitch pending
               quad_in = (cnt_ff == 6'd1) ? 2'd0 : 2'd1;
            end else cnt_in = 6'd1;
            if (cnt_ff == 6'd1) begin
               dang_in = pt[33:0] + 34'(yaw_ff);
               quad_in = 2'd0;
               cnt_in = 6'd1;
            end
         end
         ST_WRAP: begin
            // keep the pitch product in the multiplier for the return to turn
            ma = 25'(17'(lpy_ff) - 17'(cmd_ff.mouse_y));
            mb = $signed({9'd0, look_sens});
            // add or take off 64 full turns, or take off one full turn, per cycle
            if (dang_ff < 0) dang_in = dang_ff + 34'(fcpu_pkg::ANG_FULL) * 34'sd64;
            else if (dang_ff >= 34'(fcpu_pkg::ANG_FULL) * 34'sd64)
               dang_in = dang_ff - 34'(fcpu_pkg::ANG_FULL) * 34'sd64;
            else if (dang_ff >= 34'(fcpu_pkg::ANG_FULL))
               dang_in = dang_ff - 34'(fcpu_pkg::ANG_FULL);
            else begin
               if (quad_ff[0] == 1'b0 && cnt_ff == 6'd1) begin
                  yaw_in = dang_ff[15:0];
                  st_in = ST_TURN; cnt_in = 6'd2;
               end else begin
                  pit_in = dang_ff[15:0];
                  lpx_in = cmd_ff.mouse_x; lpy_in = cmd_ff.mouse_y;
                  // start yaw CORDIC
                  spy = 34'(yaw_ff);
                  quad_in = (yaw_ff >= 3 * fcpu_pkg::ANG_QUARTER) ? 2'd3 :
                            (yaw_ff >= 2 * fcpu_pkg::ANG_QUARTER) ? 2'd2 :
                            (yaw_ff >= fcpu_pkg::ANG_QUARTER) ? 2'd1 : 2'd0;
                  cz_in = 26'(spy[15:0] - 16'(quad_in) * fcpu_pkg::ANG_QUARTER) <<< 9;
                  cx_in = fcpu_pkg::CORDIC_GAIN; cy_in = '0;
                  cnt_in = '0; cmd_in.neg = 1'b0;
                  st_in = ST_CORD;
               end
            end
         end
         ST_CORD: begin
            if (!cz_ff[25]) begin
               cx_in = cx_ff - (cy_ff >>> cnt_ff[3:0]);
               cy_in = cy_ff + (cx_ff >>> cnt_ff[3:0]);
               cz_in = cz_ff - 26'(atan_v);
            end else begin
               cx_in = cx_ff + (cy_ff >>> cnt_ff[3:0]);
               cy_in = cy_ff - (cx_ff >>> cnt_ff[3:0]);
               cz_in = cz_ff + 26'(atan_v);
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd15) st_in = ST_QUAD;
         end
         ST_QUAD: begin
            if (!cmd_ff.neg) begin
               cyaw_in = qc; syaw_in = qs;
               cmd_in.neg = 1'b1;
               quad_in = (pit_ff >= 3 * fcpu_pkg::ANG_QUARTER) ? 2'd3 :
                         (pit_ff >= 2 * fcpu_pkg::ANG_QUARTER) ? 2'd2 :
                         (pit_ff >= fcpu_pkg::ANG_QUARTER) ? 2'd1 : 2'd0;
               cz_in = 26'(pit_ff - 16'(quad_in) * fcpu_pkg::ANG_QUARTER) <<< 9;
               cx_in = fcpu_pkg::CORDIC_GAIN; cy_in = '0;
               cnt_in = '0; st_in = ST_CORD;
            end else begin
               vy_in = qs;
               cx_in = 34'(qc);
               cnt_in = '0; st_in = ST_VIEW;
            end
         end
         ST_VIEW: begin
            ma = 25'(cyaw_ff);
            if (cnt_ff == 6'd1) ma = 25'(syaw_ff);
            mb = 25'(cx_ff);
            if (cnt_ff != '0) begin
               pt = (prod_ff + 50'sd8192) >>> 14;
               rounded = (pt > 50'sd16384) ? 34'sd16384 :
                         (pt < -50'sd16384) ? -34'sd16384 : pt[33:0];
               if (cnt_ff == 6'd1) vx_in = rounded[15:0];
               else vz_in = rounded[15:0];
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd2) st_in = ST_OUT;
         end
         ST_OUT: begin
            rv_in = 1'b1; st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; cnt_ff <= '0; rv_ff <= 1'b0;
         px_ff <= '0; py_ff <= '0; pz_ff <= 32'sd2048000;
         vx_ff <= '0; vy_ff <= '0; vz_ff <= -fcpu_pkg::ONE_Q14;
         yaw_ff <= 16'd34560; pit_ff <= '0; lpx_ff <= '0; lpy_ff <= '0;
         first_ff <= 1'b1; flag_ff <= 1'b0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in; rv_ff <= rv_in;
         px_ff <= px_in; py_ff <= py_in; pz_ff <= pz_in;
         vx_ff <= vx_in; vy_ff <= vy_in; vz_ff <= vz_in;
         yaw_ff <= yaw_in; pit_ff <= pit_in; lpx_ff <= lpx_in; lpy_ff <= lpy_in;
         first_ff <= first_in; flag_ff <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in;
      quad_ff <= quad_in; cyaw_ff <= cyaw_in; syaw_ff <= syaw_in; dang_ff <= dang_in;
      rem_ff <= rem_in; root_ff <= root_in; dq_ff <= dq_in; dr_ff <= dr_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_payload = '{pos_x: px_ff, pos_y: py_ff, pos_z: pz_ff,
                          front_x: vx_ff, front_y: vy_ff, front_z: vz_ff,
                          strafe_undefined: flag_ff};
endmodule

@@ rtl/fcpu_checker.sv @@
// Port-level checker for the fly camera pose block, bound to the top level.
module fcpu_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input fcpu_pkg::rsp_type rsp_payload
);
   a_front_y_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.front_y <= 16'sd16384 && rsp_payload.front_y >= -16'sd16384))
      else $error("front_y out of range");
   a_flag_keeps_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.strafe_undefined |->
         (rsp_payload.front_x == 16'sd0 && rsp_payload.front_z == 16'sd0))
      else $error("strafe flag with horizontal front");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response dropped while stalled");
endmodule

bind fly_camera_pose_update_top fcpu_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_payload(rsp.payload)
);

@@ verif/fcpu_pose_checker.sv @@
// Pose predictor and response checker for the fly camera pose block.
module fcpu_pose_checker (
   input  logic clock,
   input  logic reset,
   fcpu_chan_if.sink   req_mon,
   fcpu_chan_if.sink   rsp_mon,
   input  logic                          csr_write_enable,
   input  logic [0:0]                    csr_index,
   input  logic [fcpu_pkg::CsrWidth-1:0] csr_write_data,
   output int   mismatch_count,
   output int   pending_count
);
   localparam longint AngFull = 46080;
   localparam longint AngQuarter = 11520;

   logic [23:0] speed_reg;
   logic [15:0] sens_reg;
   logic signed [31:0] cam_x, cam_y, cam_z;
   logic signed [15:0] dir_x, dir_y, dir_z;
   longint yaw_deg, pitch_deg;
   longint prev_px, prev_py;
   logic first_look;
   fcpu_pkg::rsp_type pose_q[$];

   assign pending_count = pose_q.size();

   function automatic longint asr64(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint rnd_shift(longint v, int s);
      return (v + (64'sd1 << (s - 1))) >>> s;
   endfunction

   function automatic longint div_near(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
   endfunction

   function automatic logic signed [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic longint clip_q14(longint v);
      if (v > 16384) return 16384;
      if (v < -16384) return -16384;
      return v;
   endfunction

   function automatic longint int_sqrt(longint v);
      longint r, bit_w;
      r = 0;
      bit_w = 64'sd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= r + bit_w) begin
            v = v - (r + bit_w);
            r = (r >> 1) + bit_w;
         end else begin
            r = r >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return r;
   endfunction

   // CORDIC in Q2.30 on the angle rest within one quadrant
   task automatic cos_sin(input longint ang, output longint c, output longint s);
      longint quad, z, x, y, nx, cr, sr;
      longint atab[16];
      atab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
               14668, 7334, 3667, 1833, 917, 458, 229, 115};
      quad = (ang % AngFull) / AngQuarter;
      z = ((ang % AngFull) % AngQuarter) << 9;
      x = 652032874;
      y = 0;
      for (int i = 0; i < 16; i++) begin
         if (z >= 0) begin
            nx = x - asr64(y, i); y = y + asr64(x, i); z = z - atab[i];
         end else begin
            nx = x + asr64(y, i); y = y - asr64(x, i); z = z + atab[i];
         end
         x = nx;
      end
      cr = clip_q14(rnd_shift(x, 16));
      sr = clip_q14(rnd_shift(y, 16));
      case (quad)
         0: begin c = cr; s = sr; end
         1: begin c = -sr; s = cr; end
         2: begin c = -cr; s = -sr; end
         default: begin c = sr; s = -cr; end
      endcase
   endtask

   function automatic longint turn_angle(longint ang, longint dpix, longint sens);
      longint r;
      r = (ang + div_near(dpix * sens, 512)) % AngFull;
      if (r < 0) r = r + AngFull;
      return r;
   endfunction

   task automatic apply_event(input fcpu_pkg::req_type t);
      longint spd, sg, fx, fz, l2, len, cy, sy, cp, sp2, mx, my;
      fcpu_pkg::rsp_type r;
      logic flag;
      spd = speed_reg;
      flag = 1'b0;
      if (t.action == fcpu_pkg::ACT_KEY) begin
         if (t.key_code == fcpu_pkg::KEY_W || t.key_code == fcpu_pkg::KEY_S) begin
            sg = (t.key_code == fcpu_pkg::KEY_W) ? 1 : -1;
            cam_x = clip32(longint'(cam_x) + sg * rnd_shift(spd * dir_x, 14));
            cam_y = clip32(longint'(cam_y) + sg * rnd_shift(spd * dir_y, 14));
            cam_z = clip32(longint'(cam_z) + sg * rnd_shift(spd * dir_z, 14));
         end else if (t.key_code == fcpu_pkg::KEY_Q) begin
            cam_y = clip32(longint'(cam_y) + spd);
         end else if (t.key_code == fcpu_pkg::KEY_E) begin
            cam_y = clip32(longint'(cam_y) - spd);
         end else if (t.key_code == fcpu_pkg::KEY_A || t.key_code == fcpu_pkg::KEY_D) begin
            fx = dir_x;
            fz = dir_z;
            l2 = fx * fx + fz * fz;
            if (l2 == 0) begin
               flag = 1'b1;
            end else begin
               len = int_sqrt(l2);
               sg = (t.key_code == fcpu_pkg::KEY_D) ? 1 : -1;
               cam_x = clip32(longint'(cam_x) + sg * div_near(spd * (-fz), len));
               cam_z = clip32(longint'(cam_z) + sg * div_near(spd * fx, len));
            end
         end
      end else if (t.action == fcpu_pkg::ACT_MOUSE) begin
         mx = t.mouse_x;
         my = t.mouse_y;
         if (first_look) begin
            prev_px = mx;
            prev_py = my;
            first_look = 1'b0;
         end
         yaw_deg = turn_angle(yaw_deg, mx - prev_px, sens_reg);
         pitch_deg = turn_angle(pitch_deg, prev_py - my, sens_reg);
         prev_px = mx;
         prev_py = my;
         cos_sin(yaw_deg, cy, sy);
         cos_sin(pitch_deg, cp, sp2);
         dir_x = 16'(clip_q14(rnd_shift(cy * cp, 14)));
         dir_y = 16'(sp2);
         dir_z = 16'(clip_q14(rnd_shift(sy * cp, 14)));
      end else if (t.action == fcpu_pkg::ACT_SET) begin
         cam_x = t.new_x;
         cam_y = t.new_y;
         cam_z = t.new_z;
      end
      r.pos_x = cam_x; r.pos_y = cam_y; r.pos_z = cam_z;
      r.front_x = dir_x; r.front_y = dir_y; r.front_z = dir_z;
      r.strafe_undefined = flag;
      pose_q.push_back(r);
   endtask

   task automatic check_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      fcpu_pkg::rsp_type exp_r, got;
      if (reset) begin
         speed_reg <= 24'd20480;
         sens_reg <= 16'd6554;
         cam_x = 0; cam_y = 0; cam_z = 2048000;
         dir_x = 0; dir_y = 0; dir_z = -16384;
         yaw_deg = 34560; pitch_deg = 0;
         prev_px = 0; prev_py = 0;
         first_look = 1'b1;
         pose_q.delete();
         mismatch_count = 0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == fcpu_pkg::CSR_MOVE_SPEED) speed_reg <= csr_write_data[23:0];
            else sens_reg <= csr_write_data[15:0];
         end
         if (req_mon.valid && req_mon.ready) apply_event(req_mon.payload);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.payload;
            if (pose_q.size() == 0) begin
               $error("unexpected response transaction");
               mismatch_count++;
            end else begin
               exp_r = pose_q.pop_front();
               check_field("pos_x", exp_r.pos_x, got.pos_x);
               check_field("pos_y", exp_r.pos_y, got.pos_y);
               check_field("pos_z", exp_r.pos_z, got.pos_z);
               check_field("front_x", exp_r.front_x, got.front_x);
               check_field("front_y", exp_r.front_y, got.front_y);
               check_field("front_z", exp_r.front_z, got.front_z);
               check_field("strafe_undefined", exp_r.strafe_undefined,
                           got.strafe_undefined);
            end
         end
      end
   end
endmodule

@@ verif/tb.sv @@
// Stimulus and verdict for the fly camera pose block testbench.
module tb;
   logic clock;
   logic reset;
   logic                          csr_write_enable;
   logic [0:0]                    csr_index;
   logic [fcpu_pkg::CsrWidth-1:0] csr_write_data;
   int mismatch_count, pending_count;
   int unsigned cycle_count = 0;
   bit calm_phase;

   fcpu_chan_if #(.PayloadType(fcpu_pkg::req_type)) req_ch ();
   fcpu_chan_if #(.PayloadType(fcpu_pkg::rsp_type)) rsp_ch ();

   fly_camera_pose_update_top dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   fcpu_pose_checker checker_i (
      .clock(clock), .reset(reset), .req_mon(req_ch.sink), .rsp_mon(rsp_ch.sink),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data), .mismatch_count(mismatch_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: the slowest path is a mouse look with a long angle wrap, plus
   // response stalls; 600+ transactions stay far below this limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 900000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Response side: random back-pressure about 8% of cycles, none in calm phase.
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= calm_phase || ($urandom_range(99) >= 8);
   end

   // Send one transaction; valid may idle before it, and drops only if the
   // next one does not follow at once.
   task automatic send_event(input fcpu_pkg::req_type t);
      while (!calm_phase && $urandom_range(99) < 8) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= t;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic drain_all();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      // ignored keys produce nothing extra but let the back end settle
      repeat (150) @(posedge clock);
   endtask

   task automatic write_csr(input logic [0:0] idx, input logic [23:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic fcpu_pkg::req_type blank_event(logic [1:0] act);
      fcpu_pkg::req_type t;
      t = '0;
      t.action = act;
      return t;
   endfunction

   function automatic fcpu_pkg::req_type key_event(logic [7:0] k);
      fcpu_pkg::req_type t;
      t = blank_event(fcpu_pkg::ACT_KEY);
      t.key_code = k;
      t.mouse_x = 16'($urandom); t.mouse_y = 16'($urandom);
      return t;
   endfunction

   function automatic fcpu_pkg::req_type look_event(logic signed [15:0] x,
                                                    logic signed [15:0] y);
      fcpu_pkg::req_type t;
      t = blank_event(fcpu_pkg::ACT_MOUSE);
      t.mouse_x = x; t.mouse_y = y;
      t.key_code = 8'($urandom);
      return t;
   endfunction

   function automatic fcpu_pkg::req_type place_event(logic [31:0] x, logic [31:0] y,
                                                     logic [31:0] z);
      fcpu_pkg::req_type t;
      t = blank_event(fcpu_pkg::ACT_SET);
      t.new_x = x; t.new_y = y; t.new_z = z;
      return t;
   endfunction

   function automatic logic [7:0] pick_key();
      logic [7:0] keys[6];
      keys = '{fcpu_pkg::KEY_W, fcpu_pkg::KEY_S, fcpu_pkg::KEY_A, fcpu_pkg::KEY_D,
               fcpu_pkg::KEY_Q, fcpu_pkg::KEY_E};
      if ($urandom_range(9) == 0) return 8'($urandom);
      return keys[$urandom_range(5)];
   endfunction

   // Random mix: mostly moves and looks around the current pointer, with
   // occasional far jumps, position loads and the unused action code.
   function automatic fcpu_pkg::req_type random_event(ref logic signed [15:0] px,
                                                      ref logic signed [15:0] py);
      fcpu_pkg::req_type t;
      int sel;
      sel = $urandom_range(99);
      if (sel < 45) begin
         t = key_event(pick_key());
      end else if (sel < 80) begin
         if ($urandom_range(9) == 0) begin
            px = 16'($urandom); py = 16'($urandom);
         end else begin
            px = px + $signed(16'($urandom_range(400))) - 16'sd200;
            py = py + $signed(16'($urandom_range(400))) - 16'sd200;
         end
         t = look_event(px, py);
      end else if (sel < 95) begin
         if ($urandom_range(3) == 0) t = place_event($urandom, $urandom, $urandom);
         else t = place_event($urandom_range(8000000) - 4000000,
                              $urandom_range(8000000) - 4000000,
                              $urandom_range(8000000) - 4000000);
      end else begin
         t = blank_event(fcpu_pkg::ACT_UNUSED);
         t.key_code = 8'($urandom);
      end
      return t;
   endfunction

   initial begin
      logic signed [15:0] px, py;
      logic [23:0] speeds[4];
      logic [15:0] senses[4];
      calm_phase = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      csr_write_enable = 1'b0;
      csr_index = fcpu_pkg::CSR_MOVE_SPEED;
      csr_write_data = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset pose, strafe from the reset view, saturation, all keys.
      send_event(key_event(fcpu_pkg::KEY_W));
      send_event(key_event(fcpu_pkg::KEY_A));
      send_event(key_event(8'h00));
      send_event(key_event(8'hFF));
      send_event(blank_event(fcpu_pkg::ACT_UNUSED));
      // first look latches the point only
      send_event(look_event(16'sh7FFF, 16'sh8000));
      send_event(look_event(16'sh8000, 16'sh7FFF));
      send_event(look_event(16'sd0, 16'sd0));
      send_event(key_event(fcpu_pkg::KEY_D));
      send_event(key_event(fcpu_pkg::KEY_S));
      send_event(place_event(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
      send_event(key_event(fcpu_pkg::KEY_Q));
      send_event(key_event(fcpu_pkg::KEY_W));
      send_event(place_event(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
      send_event(key_event(fcpu_pkg::KEY_E));
      send_event(key_event(fcpu_pkg::KEY_S));
      send_event(key_event(fcpu_pkg::KEY_A));
      drain_all();

      // Extreme settings; a large pitch turn comes before the second strafe.
      write_csr(fcpu_pkg::CSR_MOVE_SPEED, 24'hFF_FFFF);
      write_csr(fcpu_pkg::CSR_LOOK_SENS, 16'hFFFF);
      send_event(key_event(fcpu_pkg::KEY_D));
      send_event(key_event(fcpu_pkg::KEY_W));
      send_event(look_event(16'sd0, 16'sd0));
      send_event(look_event(16'sd0, -16'sd703));
      send_event(key_event(fcpu_pkg::KEY_A));
      send_event(key_event(fcpu_pkg::KEY_Q));
      drain_all();

      speeds = '{24'd0, 24'd1, 24'd20480, 24'd4096};
      senses = '{16'd0, 16'd1, 16'd6554, 16'd40000};
      px = 0;
      py = 0;
      for (int phase = 0; phase < 4; phase++) begin
         write_csr(fcpu_pkg::CSR_MOVE_SPEED, phase == 3 ? 24'($urandom) : speeds[phase]);
         write_csr(fcpu_pkg::CSR_LOOK_SENS, phase == 3 ? 16'($urandom) : senses[phase]);
         calm_phase = (phase == 2);
         for (int n = 0; n < 150; n++) begin
            send_event(random_event(px, py));
            // sender holds off until everything is back
            if (n == 75) drain_all();
         end
         drain_all();
      end
      calm_phase = 1'b0;

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
rtl/fcpu_pkg.sv
rtl/fcpu_chan_if.sv
rtl/fcpu_front.sv
rtl/fcpu_back.sv
rtl/fly_camera_pose_update_top.sv
rtl/fcpu_checker.sv
verif/fcpu_pose_checker.sv
verif/tb.sv
